// ===== hdl/pgm_pkg.sv =====
// Shared constants, types and helper functions of the path glob matcher.
package pgm_pkg;

  localparam int NUM_PATTERNS = 4;
  localparam int PATTERN_LEN  = 32;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 5;
  localparam int SLOT_W    = 2;
  localparam int ACT_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 3;
  localparam int LEN_W     = $clog2(PATTERN_LEN + 1);
  localparam int IDX_W     = $clog2(PATTERN_LEN);
  localparam int EXT_W     = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_PATH = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_PATTERNS = 1'b0,
    CFG_FOLD            = 1'b1
  } cfg_reg_t;

  // One bit per pattern position, and one bit per NFA state (positions plus end).
  typedef logic [PATTERN_LEN-1:0] pos_mask_t;
  typedef logic [PATTERN_LEN:0]   state_vec_t;

  localparam state_vec_t VEC_INIT = state_vec_t'(1);

  // Command from the item stage to every pattern slot.
  typedef struct packed {
    logic              advance;
    logic              restart;
    logic              has_byte;
    logic              last;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] path_char;
  } pgm_cmd_t;

  function automatic logic [BYTE_W-1:0] pgm_fold(input logic [BYTE_W-1:0] b,
                                                 input logic on);
    logic [BYTE_W-1:0] r;
    r = b;
    if (on && b >= CH_UPPER_A && b <= CH_UPPER_Z) r = b + CASE_OFFSET;
    else if (on && b == CH_BSLASH) r = CH_SLASH;
    return r;
  endfunction

  // For every position, the parity of the run of stars that ends just before it.
  // Built as a log-depth doubling network rather than a ripple over the pattern.
  function automatic pos_mask_t pgm_run_odd(input pos_mask_t star);
    pos_mask_t all_s, par, all_n, par_n;
    all_s = star << 1;
    par   = star << 1;
    for (int w = 1; w < PATTERN_LEN; w = w * 2) begin
      all_n = all_s;
      par_n = par;
      for (int k = 0; k < PATTERN_LEN; k++) begin
        if (k >= w) begin
          all_n[k] = all_s[k] & all_s[k-w];
          par_n[k] = all_s[k] ? (par[k-w] ^ 1'(w == 1)) : par[k];
        end else begin
          all_n[k] = 1'b0;
          par_n[k] = all_s[k] ? 1'(w == 1) : par[k];
        end
      end
      all_s = all_n;
      par   = par_n;
    end
    return par;
  endfunction

  // Epsilon closure over star edges. A carry runs through star and double-star
  // positions (and the skipped second star of a pair); it is resolved with a
  // parallel-prefix network.
  function automatic state_vec_t pgm_closure(input state_vec_t v,
                                             input pos_mask_t act,
                                             input pos_mask_t skip,
                                             input state_vec_t in_edge);
    pos_mask_t  g, p, g_n, p_n;
    state_vec_t r;
    g = act & v[PATTERN_LEN-1:0];
    p = (act & in_edge[PATTERN_LEN-1:0]) | skip;
    for (int w = 1; w < PATTERN_LEN; w = w * 2) begin
      g_n = g;
      p_n = p;
      for (int k = w; k < PATTERN_LEN; k++) begin
        g_n[k] = g[k] | (p[k] & g[k-w]);
        p_n[k] = p[k] & p[k-w];
      end
      g = g_n;
      p = p_n;
    end
    r[0] = v[0];
    for (int k = 1; k <= PATTERN_LEN; k++) begin
      r[k] = v[k] | (in_edge[k] & g[k-1]);
    end
    return r;
  endfunction

endpackage

// ===== hdl/pgm_slot.sv =====
// One pattern slot: stored pattern, token decode and NFA position vector.
module pgm_slot import pgm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pgm_cmd_t cmd,
  input  logic     load_en,
  input  logic     fold_on,
  output logic     accept,
  output logic     cut
);

  logic [BYTE_W-1:0] pbytes [PATTERN_LEN];
  logic [LEN_W-1:0]  length;
  state_vec_t        state_vec;

  logic [EXT_W-1:0] pos_ext;
  logic [EXT_W-1:0] pos_plus;
  logic             pos_fits;
  logic [LEN_W-1:0] length_next;

  pos_mask_t  star, qmark, odd, skip, dstar, sstar, act, hit;
  state_vec_t in_edge, v_base, cl_now, nv, v_step;

  assign pos_ext  = EXT_W'(cmd.position);
  assign pos_plus = pos_ext + EXT_W'(1);
  assign pos_fits = pos_ext < EXT_W'(PATTERN_LEN);
  assign length_next = (pos_plus > EXT_W'(PATTERN_LEN)) ? LEN_W'(PATTERN_LEN)
                                                        : LEN_W'(pos_plus);

  always_comb begin
    for (int k = 0; k < PATTERN_LEN; k++) begin
      star[k]  = (LEN_W'(k) < length) && (pbytes[k] == CH_STAR);
      qmark[k] = (LEN_W'(k) < length) && (pbytes[k] == CH_QMARK);
    end
  end

  assign odd = pgm_run_odd(star);

  // A star at an even place in its run opens a double star when another star follows.
  always_comb begin
    for (int k = 0; k < PATTERN_LEN; k++) begin
      skip[k]  = star[k] & odd[k];
      dstar[k] = 1'b0;
      if (k < PATTERN_LEN - 1) dstar[k] = star[k] & ~odd[k] & star[k+1];
    end
  end

  assign sstar = star & ~odd & ~dstar;
  assign act   = sstar | dstar;

  always_comb begin
    in_edge[0] = 1'b0;
    for (int k = 1; k <= PATTERN_LEN; k++) begin
      in_edge[k] = sstar[k-1] | skip[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < PATTERN_LEN; k++) begin
      hit[k] = qmark[k] ||
               ((LEN_W'(k) < length) && !star[k] &&
                (pgm_fold(pbytes[k], fold_on) == cmd.path_char));
    end
  end

  assign v_base = cmd.restart ? VEC_INIT : state_vec;
  assign cl_now = pgm_closure(v_base, act, skip, in_edge);

  always_comb begin
    nv = '0;
    for (int k = 0; k < PATTERN_LEN; k++) begin
      nv[k]   = nv[k] | (cl_now[k] & ((sstar[k] & (cmd.path_char != CH_SLASH)) | dstar[k]));
      nv[k+1] = nv[k+1] | (cl_now[k] & hit[k]);
    end
  end

  assign v_step = pgm_closure(nv, act, skip, in_edge);
  assign accept = cmd.has_byte ? v_step[length] : cl_now[length];

  always_ff @(posedge clk) begin
    if (load_en && cmd.has_byte && pos_fits) begin
      pbytes[pos_ext[IDX_W-1:0]] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      cut       <= 1'b0;
      state_vec <= '0;
    end else begin
      if (load_en) begin
        if (!cmd.has_byte) begin
          length <= '0;
          cut    <= 1'b0;
        end else begin
          if (!pos_fits) cut <= 1'b1;
          else if (cmd.position == '0) cut <= 1'b0;
          if (cmd.last) length <= length_next;
        end
      end
      if (cmd.advance) begin
        state_vec <= cmd.has_byte ? v_step : v_base;
      end
    end
  end

endmodule

// ===== hdl/path_glob_matcher.sv =====
// Top level of the path glob matcher: item stage, configuration and result register.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  input    | valid / stall                | op, slot, position, byte_value, has_byte, last
//  result   | result_valid / result_stall  | matched, overflow
//  config   | cfg_write                    | cfg_index, cfg_data
//
// One item is taken per cycle unless the input stalls. An item waits in the input register while all
// pattern slots update their NFA vectors in parallel; a path item with last set puts
// its result in the result register when it leaves the input register, so the result
// is offered from the result register after the item has passed the input register.
// Reset is synchronous and clears slot lengths, cut flags, NFA vectors, valid flags and configuration.
// The input stalls only while a finished path needs the result register and a
// previous result there is itself stalled.
module path_glob_matcher import pgm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 valid,
  output logic                 stall,
  input  logic                 op,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [POS_W-1:0]     position,
  input  logic [BYTE_W-1:0]    byte_value,
  input  logic                 has_byte,
  input  logic                 last,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 matched,
  output logic                 overflow
);

  logic [ACT_W-1:0] active_patterns;
  logic             fold_case_and_slash;
  logic             at_path_start;

  logic              s1_valid;
  op_t               s1_op;
  logic [SLOT_W-1:0] s1_slot;
  logic [POS_W-1:0]  s1_position;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_has;
  logic              s1_last;

  logic s1_result, s1_go;
  pgm_cmd_t cmd;
  logic [NUM_PATTERNS-1:0] load_en, accept, cut, active;

  assign s1_result = s1_valid && (s1_op == OP_PATH) && s1_last;
  assign s1_go     = s1_valid && !(s1_result && result_valid && result_stall);
  assign stall     = s1_valid && !s1_go;

  always_comb begin
    cmd.advance   = s1_go && (s1_op == OP_PATH);
    cmd.restart   = at_path_start;
    cmd.has_byte  = s1_has;
    cmd.last      = s1_last;
    cmd.position  = s1_position;
    cmd.data      = s1_byte;
    cmd.path_char = pgm_fold(s1_byte, fold_case_and_slash);
  end

  for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_slot
    assign load_en[i] = s1_go && (s1_op == OP_LOAD) && (32'(s1_slot) == i);
    assign active[i]  = 32'(active_patterns) > i;

    pgm_slot u_slot (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .load_en (load_en[i]),
      .fold_on (fold_case_and_slash),
      .accept  (accept[i]),
      .cut     (cut[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!stall && valid) begin
      s1_op       <= op_t'(op);
      s1_slot     <= slot;
      s1_position <= position;
      s1_byte     <= byte_value;
      s1_has      <= has_byte;
      s1_last     <= last;
    end
    if (s1_go && s1_result) begin
      matched  <= |(accept & active);
      overflow <= |(cut & active);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid            <= 1'b0;
      result_valid        <= 1'b0;
      at_path_start       <= 1'b1;
      active_patterns     <= '0;
      fold_case_and_slash <= 1'b0;
    end else begin
      if (!stall) s1_valid <= valid;
      if (s1_go && s1_result) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      if (cmd.advance) at_path_start <= s1_last;
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ACTIVE_PATTERNS: active_patterns <= cfg_data[ACT_W-1:0];
          CFG_FOLD:            fold_case_and_slash <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/pgm_checker.sv =====
// Port-level checks of the path glob matcher and their binding to the top level.
module pgm_checker import pgm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic stall,
  input logic op,
  input logic last,
  input logic result_valid,
  input logic result_stall,
  input logic matched,
  input logic overflow
);

  // A held result stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(matched) && $stable(overflow))
    else $error("result changed while stalled");

  // The input is only held back by a result that cannot leave.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    stall |-> result_valid && result_stall)
    else $error("input stalled without a blocked result");

  // A new result follows an accepted path item that had last set.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(valid && !stall && (op == OP_PATH) && last, 2))
    else $error("result without a finished path");

endmodule

bind path_glob_matcher pgm_checker u_pgm_checker (.*);
